// ----- design/prefix_rolling_hash_table_top_assert.svh -----
// Assertion macros for the prefix rolling hash table.
// Included by the top level; needs nothing else.
`ifndef PREFIX_ROLLING_HASH_TABLE_TOP_ASSERT_SVH
`define PREFIX_ROLLING_HASH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication under a synchronous reset.
`define PRHT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prht: same-cycle check failed");

// Next-cycle implication under a synchronous reset.
`define PRHT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prht: next-cycle check failed");

`endif

// ----- design/prht_pkg.sv -----
// Shared types and codes for the prefix rolling hash table.
// No dependencies.
package prht_pkg;

   localparam logic [1:0] KIND_APPEND   = 2'd0;
   localparam logic [1:0] KIND_QUERY    = 2'd1;
   localparam logic [1:0] KIND_CLEAR    = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   localparam logic [1:0] CSR_HASH_BASE    = 2'd0;
   localparam logic [1:0] CSR_HASH_MODULUS = 2'd1;
   localparam logic [1:0] CSR_MODULAR_MODE = 2'd2;

   localparam logic [63:0] RESET_HASH_BASE    = 64'd1000000007;
   localparam logic [30:0] RESET_HASH_MODULUS = 31'd1000000007;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_APP_RD,
      ST_APP_LD,
      ST_MOD_BASE,
      ST_MOD_H,
      ST_MOD_P,
      ST_MUL_PB,
      ST_MUL_HB,
      ST_ADD_C,
      ST_QRY_RD1,
      ST_QRY_LD1,
      ST_QRY_RD2,
      ST_QRY_LD2,
      ST_MOD_HJ,
      ST_MOD_HI,
      ST_MOD_QP,
      ST_MUL_QT,
      ST_QRY_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic modular;
   } mm_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mm_stat_type;

endpackage

// ----- design/prht_channels.sv -----
// Valid/ready channel interfaces for request and response transactions.
// Depends on prht_pkg.
interface prht_req_if import prht_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  char_value;
   logic [10:0] start_index;
   logic [10:0] end_index;

   modport source (output valid, kind, char_value, start_index, end_index, input ready);
   modport sink   (input valid, kind, char_value, start_index, end_index, output ready);
endinterface

interface prht_rsp_if import prht_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;
   logic [1:0]  status;

   modport source (output valid, hash_value, status, input ready);
   modport sink   (input valid, hash_value, status, output ready);
endinterface

// ----- design/prht_mulmod.sv -----
// Bit-serial multiplier: a*b mod m (modular) or mod 2^64 (wrap).
// Depends on prht_pkg. In modular mode a must be below m.
module prht_mulmod import prht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mm_ctrl_type ctrl,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   input  logic [30:0] modulus,
   output mm_stat_type stat,
   output logic [63:0] result
);

   logic [63:0] r_ff, a_ff, b_ff;
   logic [30:0] m_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff, mod_ff;
   logic [63:0] sum, r_in;
   logic [32:0] m33, red1, red2;

   always_comb begin
      sum  = {r_ff[62:0], 1'b0} + (b_ff[63] ? a_ff : 64'd0);
      m33  = {2'b00, m_ff};
      red1 = (sum[32:0] >= m33) ? sum[32:0] - m33 : sum[32:0];
      red2 = (red1 >= m33) ? red1 - m33 : red1;
      r_in = mod_ff ? {31'd0, red2} : sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Payload: load operands on start, shift the multiplier out MSB first.
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         r_ff   <= '0;
         a_ff   <= op_a;
         b_ff   <= op_b;
         m_ff   <= modulus;
         mod_ff <= ctrl.modular;
      end else if (busy_ff) begin
         r_ff <= r_in;
         b_ff <= {b_ff[62:0], 1'b0};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = r_ff;

endmodule

// ----- design/prefix_rolling_hash_table_top.sv -----
// Prefix rolling hash table: prefix hashes and base powers in two registered-read RAMs.
// Clear, kind 3, a full append and a bad query load the response register at acceptance;
// other appends and queries answer after passes (start, steps, done) of the one shared
// bit-serial mulmod unit, with more passes in modular mode than in wrap mode.
// One transaction in flight; the next is taken once the response register is free. Sync
// active-high reset clears length, control and config; RAM stays undefined, entry zero muxed.
module prefix_rolling_hash_table_top import prht_pkg::*; #(
   parameter int MAX_LENGTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   prht_req_if.sink    req_bus,
   prht_rsp_if.source  rsp_bus,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   localparam int DEPTH = MAX_LENGTH + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = (AW > 11) ? AW : 11;

   // Configuration registers.
   logic [63:0] base_ff;
   logic [30:0] modulus_ff;
   logic        modular_ff;
   logic [30:0] cur_m;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= RESET_HASH_BASE;
         modulus_ff <= RESET_HASH_MODULUS;
         modular_ff <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HASH_BASE:    base_ff    <= csr_write_data;
            CSR_HASH_MODULUS: modulus_ff <= csr_write_data[30:0];
            CSR_MODULAR_MODE: modular_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Treat a modulus below two as two.
   assign cur_m = (modulus_ff < 31'd2) ? 31'd2 : modulus_ff;

   // Control and datapath registers.
   state_type   state_ff, state_in;
   logic [AW-1:0] len_ff, s_ff, e_ff;
   logic [7:0]  c_ff;
   logic [63:0] h_ff, p_ff, b_ff, t_ff, hj_ff, hv_ff;
   logic        launched_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_hash_ff;
   logic [1:0]  rsp_status_ff;

   // Memories and their read ports.
   logic [63:0] hash_mem  [0:DEPTH-1];
   logic [63:0] power_mem [0:DEPTH-1];
   logic [AW-1:0] h_rd_addr, p_rd_addr, wr_addr;
   logic [63:0] h_rd_ff, p_rd_ff;
   logic        h_zero_ff, p_zero_ff;
   logic [63:0] h_rd_val, p_rd_val;
   logic        h_we, p_we;

   // Mulmod unit.
   mm_ctrl_type mm_ctrl;
   mm_stat_type mm_stat;
   logic [63:0] mm_a, mm_b, mm_res;
   logic        op_state;

   // Handshake helpers.
   logic        out_free, req_fire, quick_load;
   logic [1:0]  quick_status;
   logic [CW-1:0] s_ext, e_ext, len_ext;
   logic        bad_range, is_full;
   logic [32:0] fin_diff;
   logic [63:0] fin_val;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire = req_bus.valid && req_bus.ready;

   assign s_ext     = CW'(req_bus.start_index);
   assign e_ext     = CW'(req_bus.end_index);
   assign len_ext   = CW'(len_ff);
   assign bad_range = (s_ext > e_ext) || (e_ext > len_ext);
   assign is_full   = (len_ext == CW'(MAX_LENGTH));

   // Pick read addresses by step; entry zero is a constant, not a RAM word.
   always_comb begin
      h_rd_addr = len_ff;
      p_rd_addr = len_ff;
      unique case (state_ff)
         ST_QRY_RD1: begin
            h_rd_addr = e_ff;
            p_rd_addr = e_ff - s_ff;
         end
         ST_QRY_RD2: h_rd_addr = s_ff;
         default: ;
      endcase
   end

   assign wr_addr  = len_ff + AW'(1);
   assign h_rd_val = h_zero_ff ? 64'd0 : h_rd_ff;
   assign p_rd_val = p_zero_ff ? 64'd1 : p_rd_ff;

   always_ff @(posedge clock) begin
      if (h_we) begin
         hash_mem[wr_addr] <= mm_stat.done ? mm_res : t_ff + 64'(c_ff);
      end
      h_rd_ff   <= hash_mem[h_rd_addr];
      h_zero_ff <= (h_rd_addr == '0);
   end

   always_ff @(posedge clock) begin
      if (p_we) begin
         power_mem[wr_addr] <= mm_res;
      end
      p_rd_ff   <= power_mem[p_rd_addr];
      p_zero_ff <= (p_rd_addr == '0);
   end

   // Operand select for the shared mulmod unit.
   always_comb begin
      mm_a     = 64'd1;
      mm_b     = h_ff;
      op_state = 1'b1;
      unique case (state_ff)
         ST_MOD_BASE: mm_b = base_ff;
         ST_MOD_H:    mm_b = h_ff;
         ST_MOD_P:    mm_b = p_ff;
         ST_MUL_PB: begin
            mm_a = p_ff;
            mm_b = modular_ff ? b_ff : base_ff;
         end
         ST_MUL_HB: begin
            mm_a = h_ff;
            mm_b = modular_ff ? b_ff : base_ff;
         end
         ST_ADD_C:  begin
            mm_b     = t_ff + 64'(c_ff);
            op_state = modular_ff;
         end
         ST_MOD_HJ: mm_b = hj_ff;
         ST_MOD_HI: mm_b = h_ff;
         ST_MOD_QP: mm_b = p_ff;
         ST_MUL_QT: begin
            mm_a = h_ff;
            mm_b = p_ff;
         end
         default: op_state = 1'b0;
      endcase
   end

   assign mm_ctrl.start   = op_state && !launched_ff;
   assign mm_ctrl.modular = modular_ff;

   prht_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mm_ctrl),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (cur_m),
      .stat    (mm_stat),
      .result  (mm_res)
   );

   assign p_we = (state_ff == ST_MUL_PB) && mm_stat.done;
   assign h_we = (state_ff == ST_ADD_C) && (mm_stat.done || !modular_ff);

   // Final subtraction of a query.
   always_comb begin
      fin_diff = {2'b00, hj_ff[30:0]} + {2'b00, cur_m} - {2'b00, t_ff[30:0]};
      if (fin_diff >= {2'b00, cur_m}) begin
         fin_diff = fin_diff - {2'b00, cur_m};
      end
      fin_val = modular_ff ? {31'd0, fin_diff} : hj_ff - t_ff;
   end

   // Next state and the immediate results decided at acceptance.
   always_comb begin
      state_in     = state_ff;
      quick_load   = 1'b0;
      quick_status = STATUS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.kind)
                  KIND_APPEND: begin
                     if (is_full) begin
                        quick_load   = 1'b1;
                        quick_status = STATUS_FULL;
                     end else begin
                        state_in = ST_APP_RD;
                     end
                  end
                  KIND_QUERY: begin
                     if (bad_range) begin
                        quick_load   = 1'b1;
                        quick_status = STATUS_BAD_RANGE;
                     end else begin
                        state_in = ST_QRY_RD1;
                     end
                  end
                  default: quick_load = 1'b1;
               endcase
            end
         end
         ST_APP_RD:   state_in = ST_APP_LD;
         ST_APP_LD:   state_in = modular_ff ? ST_MOD_BASE : ST_MUL_PB;
         ST_MOD_BASE: if (mm_stat.done) state_in = ST_MOD_H;
         ST_MOD_H:    if (mm_stat.done) state_in = ST_MOD_P;
         ST_MOD_P:    if (mm_stat.done) state_in = ST_MUL_PB;
         ST_MUL_PB:   if (mm_stat.done) state_in = ST_MUL_HB;
         ST_MUL_HB:   if (mm_stat.done) state_in = ST_ADD_C;
         ST_ADD_C:    if (h_we) state_in = ST_DONE;
         ST_QRY_RD1:  state_in = ST_QRY_LD1;
         ST_QRY_LD1:  state_in = ST_QRY_RD2;
         ST_QRY_RD2:  state_in = ST_QRY_LD2;
         ST_QRY_LD2:  state_in = modular_ff ? ST_MOD_HJ : ST_MUL_QT;
         ST_MOD_HJ:   if (mm_stat.done) state_in = ST_MOD_HI;
         ST_MOD_HI:   if (mm_stat.done) state_in = ST_MOD_QP;
         ST_MOD_QP:   if (mm_stat.done) state_in = ST_MUL_QT;
         ST_MUL_QT:   if (mm_stat.done) state_in = ST_QRY_FIN;
         ST_QRY_FIN:  state_in = ST_DONE;
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // Mark a launched pass; drop the mark when the unit reports done.
         if (mm_ctrl.start) begin
            launched_ff <= 1'b1;
         end else if (mm_stat.done) begin
            launched_ff <= 1'b0;
         end
         if (req_fire && req_bus.kind == KIND_CLEAR) begin
            len_ff <= '0;
         end else if (h_we) begin
            len_ff <= wr_addr;
         end
         if (quick_load || (state_ff == ST_DONE && out_free)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers: capture operands and unit results by step.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         c_ff <= req_bus.char_value;
         s_ff <= s_ext[AW-1:0];
         e_ff <= e_ext[AW-1:0];
      end
      case (state_ff)
         ST_APP_LD: begin
            h_ff <= h_rd_val;
            p_ff <= p_rd_val;
         end
         ST_QRY_LD1: begin
            hj_ff <= h_rd_val;
            p_ff  <= p_rd_val;
         end
         ST_QRY_LD2: h_ff <= h_rd_val;
         ST_MOD_BASE: if (mm_stat.done) b_ff <= mm_res;
         ST_MOD_H, ST_MOD_HI: if (mm_stat.done) h_ff <= mm_res;
         ST_MOD_P, ST_MOD_QP: if (mm_stat.done) p_ff <= mm_res;
         ST_MOD_HJ: if (mm_stat.done) hj_ff <= mm_res;
         ST_MUL_HB, ST_MUL_QT: if (mm_stat.done) t_ff <= mm_res;
         ST_ADD_C: if (h_we) hv_ff <= modular_ff ? mm_res : t_ff + 64'(c_ff);
         ST_QRY_FIN: hv_ff <= fin_val;
         default: ;
      endcase
      if (quick_load) begin
         rsp_hash_ff   <= 64'd0;
         rsp_status_ff <= quick_status;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_hash_ff   <= hv_ff;
         rsp_status_ff <= STATUS_OK;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.hash_value = rsp_hash_ff;
   assign rsp_bus.status     = rsp_status_ff;

`include "prefix_rolling_hash_table_top_assert.svh"

   `PRHT_ASSERT_IMP(a_len_bound, clock, reset, 1'b1, len_ext <= CW'(MAX_LENGTH))
   `PRHT_ASSERT_NXT(a_accept_moves, clock, reset, req_fire, rsp_valid_ff || state_ff != ST_IDLE)
   `PRHT_ASSERT_IMP(a_start_idle_unit, clock, reset, mm_ctrl.start, !mm_stat.busy)

endmodule
